[rtl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// Pressure/temperature compensation package
// Shared types, register indexes, fixed constants and extension helpers of
// the compensation datapath and its arithmetic units.
// ----------------------------------------------------------------------------
package ptc_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TEMP    = 2'd0;
	localparam logic [1:0] CFG_PRESS_A = 2'd1;
	localparam logic [1:0] CFG_PRESS_B = 2'd2;
	localparam logic [1:0] CFG_PRESS_C = 2'd3;

	// Fixed constants of the compensation formulae.
	localparam logic [63:0] TEMP_OFFSET      = 64'd128000;
	localparam logic [63:0] PRESS_FULL_SCALE = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE      = 64'd3125;
	localparam logic [63:0] ROUND_HALF       = 64'd128;
	localparam logic [63:0] P1_BIAS          = 64'h0000_8000_0000_0000;

	// Request to a shared arithmetic unit: operands are taken on start.
	typedef struct packed {
		logic        start;
		logic [63:0] op_a;
		logic [63:0] op_b;
	} ptc_op_req_t;

	// Response of a shared arithmetic unit: value is valid while done is high.
	typedef struct packed {
		logic        done;
		logic [63:0] value;
	} ptc_op_rsp_t;

	function automatic logic [63:0] sext16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] zext16(input logic [15:0] v);
		return {48'd0, v};
	endfunction

	function automatic logic [63:0] sext32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

endpackage

[rtl/ptc_mul.sv]
// ----------------------------------------------------------------------------
// Shared 64-bit multiplier
// Forms the low 64 bits of a 64 x 64 product with one 32 x 32 multiplier,
// accumulating the low-low, high-low and low-high partial products.
// ----------------------------------------------------------------------------
module ptc_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  ptc_pkg::ptc_op_req_t req,
	output ptc_pkg::ptc_op_rsp_t rsp
);

	localparam logic [1:0] STEP_LL = 2'd0;
	localparam logic [1:0] STEP_HL = 2'd1;
	localparam logic [1:0] STEP_LH = 2'd2;

	logic        busy_q;
	logic        done_q;
	logic [1:0]  step_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [31:0] x;
	logic [31:0] y;
	logic [63:0] pp;

	always_comb begin
		case (step_q)
			STEP_LL: begin
				x = a_q[31:0];
				y = b_q[31:0];
			end
			STEP_HL: begin
				x = a_q[63:32];
				y = b_q[31:0];
			end
			default: begin
				x = a_q[31:0];
				y = b_q[63:32];
			end
		endcase
		pp = {32'd0, x} * {32'd0, y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= STEP_LL;
		end else begin
			done_q <= busy_q && (step_q == STEP_LH);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_LL;
			end else if (busy_q) begin
				if (step_q == STEP_LH) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	// Only the low halves of the cross products reach the low 64 bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.op_a;
			b_q <= req.op_b;
		end
		if (busy_q) begin
			if (step_q == STEP_LL) begin
				acc_q <= pp;
			end else begin
				acc_q <= acc_q + {pp[31:0], 32'd0};
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = acc_q;

endmodule

[rtl/ptc_div.sv]
// ----------------------------------------------------------------------------
// Shared signed 64-bit divider
// Restoring division of magnitudes, one quotient bit per cycle, with the
// sign applied in a final step. The quotient truncates toward zero.
// ----------------------------------------------------------------------------
module ptc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ptc_pkg::ptc_op_req_t req,
	output ptc_pkg::ptc_op_rsp_t rsp
);

	localparam int unsigned STEPS = 64;
	localparam int unsigned CNT_W = $clog2(STEPS);

	logic             busy_q;
	logic             fix_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [63:0]      rem_q;
	logic [63:0]      quo_q;
	logic [63:0]      den_q;
	logic [63:0]      res_q;
	logic [64:0]      trial;
	logic [64:0]      diff;
	logic             fits;
	logic             last;
	logic [63:0]      mag_a;
	logic [63:0]      mag_b;

	assign mag_a = req.op_a[63] ? (64'd0 - req.op_a) : req.op_a;
	assign mag_b = req.op_b[63] ? (64'd0 - req.op_b) : req.op_b;
	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = !diff[64];
	assign last  = (cnt_q == CNT_W'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fix_q;
			fix_q  <= busy_q && last;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.op_a[63] ^ req.op_b[63];
			rem_q <= '0;
			quo_q <= mag_a;
			den_q <= mag_b;
		end else if (busy_q) begin
			rem_q <= fits ? diff[63:0] : trial[63:0];
			quo_q <= {quo_q[62:0], fits};
		end
		if (fix_q) begin
			res_q <= neg_q ? (64'd0 - quo_q) : quo_q;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

[rtl/pressure_temperature_compensation.sv]
// ----------------------------------------------------------------------------
// Pressure and temperature compensation
// One transaction at a time: the next is accepted after the result of the
// last one is loaded into the result register. The pace is set by the shared
// multiplier and the bit-serial divider; a pressure transaction with a zero
// divisor skips the division. Reset clears the calibration registers, the
// stored fine temperature and all handshakes.
//
// A small sequencer drives one shared 64-bit multiplier and one divider
// through the published integer compensation, holding intermediates in a
// handful of 64-bit working registers.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
	input  logic               clk,
	input  logic               arst_n,
	// Input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [19:0]        raw_sample,
	// Result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic signed [31:0] temp_centi,
	output logic [31:0]        pressure_q24_8,
	output logic               div_fault,
	// Configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	// One-hot sequencer states. Each multiply state issues one product to the
	// shared multiplier and retires it when the unit reports done.
	typedef enum logic [18:0] {
		S_IDLE  = 19'h00001,
		S_T_M1  = 19'h00002,
		S_T_M2  = 19'h00004,
		S_T_M3  = 19'h00008,
		S_T_FIN = 19'h00010,
		S_P_AA  = 19'h00020,
		S_P_B6  = 19'h00040,
		S_P_B5  = 19'h00080,
		S_P_A3  = 19'h00100,
		S_P_A2  = 19'h00200,
		S_P_A1  = 19'h00400,
		S_P_CHK = 19'h00800,
		S_P_NUM = 19'h01000,
		S_P_DIV = 19'h02000,
		S_P_M9A = 19'h04000,
		S_P_M9B = 19'h08000,
		S_P_M8  = 19'h10000,
		S_P_FIN = 19'h20000,
		S_OUT   = 19'h40000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Calibration registers and stored fine temperature.
	logic [47:0] temp_calib_q;
	logic [47:0] press_a_q;
	logic [47:0] press_b_q;
	logic [47:0] press_c_q;
	logic [31:0] fine_q;

	// Working registers of the current transaction.
	logic        issued_q;
	logic        req_kind_q;
	logic [19:0] raw_q;
	logic [63:0] ra_q;
	logic [63:0] raa_q;
	logic [63:0] rb_q;
	logic [63:0] rx_q;
	logic [31:0] res_temp_q;
	logic [31:0] res_press_q;
	logic        res_fault_q;

	// Result register: the sequencer goes back to idle once the result sits
	// here, so a new transaction can be taken while this one waits.
	logic        out_valid_q;
	logic        out_kind_q;
	logic [31:0] out_temp_q;
	logic [31:0] out_press_q;
	logic        out_fault_q;

	ptc_pkg::ptc_op_req_t mul_req;
	ptc_pkg::ptc_op_rsp_t mul_rsp;
	ptc_pkg::ptc_op_req_t div_req;
	ptc_pkg::ptc_op_rsp_t div_rsp;

	logic        in_accept;
	logic        out_load;
	logic [63:0] prod;
	logic [63:0] t1;
	logic [63:0] t2;
	logic [63:0] t3;
	logic [63:0] p1;
	logic [63:0] p2;
	logic [63:0] p3;
	logic [63:0] p4;
	logic [63:0] p5;
	logic [63:0] p6;
	logic [63:0] p7;
	logic [63:0] p8;
	logic [63:0] p9;
	logic [63:0] t_d1;
	logic [63:0] t_d2;
	logic [63:0] fine_ext;
	logic [63:0] temp_sum;
	logic [31:0] temp_w;
	logic [31:0] fine_w;
	logic [63:0] num_w;
	logic [63:0] ps_w;
	logic [63:0] press_sum;
	logic [63:0] press_w;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign prod      = mul_rsp.value;

	// Coefficients: the first of each register is in bits 15:0.
	assign t1 = ptc_pkg::zext16(temp_calib_q[15:0]);
	assign t2 = ptc_pkg::sext16(temp_calib_q[31:16]);
	assign t3 = ptc_pkg::sext16(temp_calib_q[47:32]);
	assign p1 = ptc_pkg::zext16(press_a_q[15:0]);
	assign p2 = ptc_pkg::sext16(press_a_q[31:16]);
	assign p3 = ptc_pkg::sext16(press_a_q[47:32]);
	assign p4 = ptc_pkg::sext16(press_b_q[15:0]);
	assign p5 = ptc_pkg::sext16(press_b_q[31:16]);
	assign p6 = ptc_pkg::sext16(press_b_q[47:32]);
	assign p7 = ptc_pkg::sext16(press_c_q[15:0]);
	assign p8 = ptc_pkg::sext16(press_c_q[31:16]);
	assign p9 = ptc_pkg::sext16(press_c_q[47:32]);

	// Temperature terms. The differences are small, so the products are exact.
	assign t_d1 = {47'd0, raw_q[19:3]} - {47'd0, temp_calib_q[15:0], 1'b0};
	assign t_d2 = {48'd0, raw_q[19:4]} - t1;
	assign fine_w = 32'(ra_q + 64'($signed(prod) >>> 14));

	// Centidegrees are (fine * 5 + 128) >> 8; the times five is a shift and add.
	assign fine_ext = ptc_pkg::sext32(fine_q);
	assign temp_sum = {fine_ext[61:0], 2'b00} + fine_ext + ptc_pkg::ROUND_HALF;
	assign temp_w   = 32'($signed(temp_sum) >>> 8);

	// Pressure terms. All of this arithmetic wraps modulo 2^64.
	assign num_w     = ((ptc_pkg::PRESS_FULL_SCALE - {44'd0, raw_q}) << 31) - rb_q;
	assign ps_w      = 64'($signed(ra_q) >>> 13);
	assign press_sum = ra_q + rx_q + rb_q;
	assign press_w   = 64'($signed(press_sum) >>> 8) + (p7 << 4);

	// Operand selection for the shared units.
	always_comb begin
		mul_req.start = 1'b0;
		mul_req.op_a  = '0;
		mul_req.op_b  = '0;
		div_req.start = 1'b0;
		div_req.op_a  = raa_q;
		div_req.op_b  = rx_q;
		unique case (state_q)
			S_T_M1: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = t_d1;
				mul_req.op_b  = t2;
			end
			S_T_M2: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = t_d2;
				mul_req.op_b  = t_d2;
			end
			S_T_M3: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = 64'($signed(raa_q) >>> 12);
				mul_req.op_b  = t3;
			end
			S_P_AA: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = ra_q;
				mul_req.op_b  = ra_q;
			end
			S_P_B6: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = raa_q;
				mul_req.op_b  = p6;
			end
			S_P_B5: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = ra_q;
				mul_req.op_b  = p5;
			end
			S_P_A3: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = raa_q;
				mul_req.op_b  = p3;
			end
			S_P_A2: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = ra_q;
				mul_req.op_b  = p2;
			end
			S_P_A1: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = ptc_pkg::P1_BIAS + rx_q;
				mul_req.op_b  = p1;
			end
			S_P_NUM: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = num_w;
				mul_req.op_b  = ptc_pkg::PRESS_SCALE;
			end
			S_P_DIV: begin
				div_req.start = !issued_q;
			end
			S_P_M9A: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = p9;
				mul_req.op_b  = ps_w;
			end
			S_P_M9B: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = rx_q;
				mul_req.op_b  = ps_w;
			end
			S_P_M8: begin
				mul_req.start = !issued_q;
				mul_req.op_a  = p8;
				mul_req.op_b  = ra_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_accept) state_d = req_type ? S_P_AA : S_T_M1;
			S_T_M1:  if (mul_rsp.done) state_d = S_T_M2;
			S_T_M2:  if (mul_rsp.done) state_d = S_T_M3;
			S_T_M3:  if (mul_rsp.done) state_d = S_T_FIN;
			S_T_FIN: state_d = S_OUT;
			S_P_AA:  if (mul_rsp.done) state_d = S_P_B6;
			S_P_B6:  if (mul_rsp.done) state_d = S_P_B5;
			S_P_B5:  if (mul_rsp.done) state_d = S_P_A3;
			S_P_A3:  if (mul_rsp.done) state_d = S_P_A2;
			S_P_A2:  if (mul_rsp.done) state_d = S_P_A1;
			S_P_A1:  if (mul_rsp.done) state_d = S_P_CHK;
			S_P_CHK: state_d = (rx_q == 64'd0) ? S_OUT : S_P_NUM;
			S_P_NUM: if (mul_rsp.done) state_d = S_P_DIV;
			S_P_DIV: if (div_rsp.done) state_d = S_P_M9A;
			S_P_M9A: if (mul_rsp.done) state_d = S_P_M9B;
			S_P_M9B: if (mul_rsp.done) state_d = S_P_M8;
			S_P_M8:  if (mul_rsp.done) state_d = S_P_FIN;
			S_P_FIN: state_d = S_OUT;
			S_OUT:   if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control state, calibration and the stored fine temperature.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issued_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			temp_calib_q <= '0;
			press_a_q    <= '0;
			press_b_q    <= '0;
			press_c_q    <= '0;
			fine_q       <= '0;
		end else begin
			state_q <= state_d;
			if (mul_req.start || div_req.start) begin
				issued_q <= 1'b1;
			end else if (mul_rsp.done || div_rsp.done) begin
				issued_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					ptc_pkg::CFG_TEMP:    temp_calib_q <= cfg_data;
					ptc_pkg::CFG_PRESS_A: press_a_q    <= cfg_data;
					ptc_pkg::CFG_PRESS_B: press_b_q    <= cfg_data;
					ptc_pkg::CFG_PRESS_C: press_c_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			if ((state_q == S_T_M3) && mul_rsp.done) begin
				fine_q <= fine_w;
			end
		end
	end

	// Working registers. In the temperature sequence ra_q holds the first
	// term and raa_q the squared difference; in the pressure sequence ra_q
	// holds the offset fine temperature and later the quotient.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					raw_q      <= raw_sample;
					req_kind_q <= req_type;
					ra_q       <= fine_ext - ptc_pkg::TEMP_OFFSET;
				end
			end
			S_T_M1:  if (mul_rsp.done) ra_q <= 64'($signed(prod) >>> 11);
			S_T_M2:  if (mul_rsp.done) raa_q <= prod;
			S_T_M3: begin
			end
			S_T_FIN: begin
				res_temp_q  <= temp_w;
				res_press_q <= '0;
				res_fault_q <= 1'b0;
			end
			S_P_AA:  if (mul_rsp.done) raa_q <= prod;
			S_P_B6:  if (mul_rsp.done) rb_q <= prod;
			S_P_B5:  if (mul_rsp.done) rb_q <= rb_q + (prod << 17) + (p4 << 35);
			S_P_A3:  if (mul_rsp.done) rx_q <= 64'($signed(prod) >>> 8);
			S_P_A2:  if (mul_rsp.done) rx_q <= rx_q + (prod << 12);
			S_P_A1:  if (mul_rsp.done) rx_q <= 64'($signed(prod) >>> 33);
			S_P_CHK: begin
				// A zero divisor ends the transaction with a fault result.
				res_temp_q  <= '0;
				res_press_q <= '0;
				res_fault_q <= 1'b1;
			end
			S_P_NUM: if (mul_rsp.done) raa_q <= prod;
			S_P_DIV: if (div_rsp.done) ra_q <= div_rsp.value;
			S_P_M9A: if (mul_rsp.done) rx_q <= prod;
			S_P_M9B: if (mul_rsp.done) rx_q <= 64'($signed(prod) >>> 25);
			S_P_M8:  if (mul_rsp.done) rb_q <= 64'($signed(prod) >>> 19);
			S_P_FIN: begin
				res_temp_q  <= '0;
				res_press_q <= press_w[31:0];
				res_fault_q <= 1'b0;
			end
			S_OUT: begin
				if (out_load) begin
					out_kind_q  <= req_kind_q;
					out_temp_q  <= res_temp_q;
					out_press_q <= res_press_q;
					out_fault_q <= res_fault_q;
				end
			end
			default: begin
			end
		endcase
	end

	ptc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	ptc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_valid      = out_valid_q;
	assign kind           = out_kind_q;
	assign temp_centi     = out_temp_q;
	assign pressure_q24_8 = out_press_q;
	assign div_fault      = out_fault_q;

	// A fault result is a pressure result with both value fields cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_fault |-> kind && (pressure_q24_8 == 32'd0) && (temp_centi == 32'sd0))
		else $error("fault result carries a value or the wrong kind");

	// A temperature result leaves the pressure fields clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> (pressure_q24_8 == 32'd0) && !div_fault)
		else $error("temperature result carries pressure fields");

	// The divider is only ever started with a nonzero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (div_req.op_b != 64'd0))
		else $error("divider started with a zero divisor");

	// A unit only reports done for an operation the sequencer issued.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mul_rsp.done || div_rsp.done) |-> issued_q)
		else $error("arithmetic unit done without an issued operation");

	// The shared units are never started together.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req.start && div_req.start))
		else $error("multiplier and divider started together");

endmodule

[dv/tb_pressure_temperature_compensation.sv]
// ----------------------------------------------------------------------------
// Pressure and temperature compensation testbench
// Drives raw temperature and pressure transactions through the block under a
// sequence of calibration settings, from the datasheet example to the signed
// extremes and fully random words. A scoreboard class predicts every result
// bit for bit and checks the result stream in order. Both channels idle at
// random, apart from a calm stretch at the end of the run.
// ----------------------------------------------------------------------------
module tb_pressure_temperature_compensation;

	// Generous ceiling on the run, far above what the slowest correct transaction
	// needs together with the longest sender gap and result stall.
	localparam int unsigned CYCLE_LIMIT = 1000000;

	// Settling time after the last result, somewhat above the pressure latency.
	localparam int unsigned TAIL_CYCLES = 150;

	// Typical raw readings, used as the centre of most random samples.
	localparam int unsigned RAW_TEMP_CENTRE  = 519888;
	localparam int unsigned RAW_PRESS_CENTRE = 415148;
	localparam logic [19:0] RAW_MAX          = 20'hFFFFF;

	// One compensated reading as it leaves the block.
	typedef struct packed {
		logic        kind;
		logic [31:0] temp;
		logic [31:0] press;
		logic        fault;
	} reading_t;

	// Scoreboard: holds its own copy of the calibration words and of the fine
	// temperature, works out each reading when its transaction is accepted and
	// compares results against the oldest reading still due.
	class reading_tracker;
		logic [47:0] temp_cal;
		logic [47:0] press_cal_a;
		logic [47:0] press_cal_b;
		logic [47:0] press_cal_c;
		logic [31:0] fine_temp;
		reading_t    readings_due[$];
		int          mismatches;

		function new();
			temp_cal    = '0;
			press_cal_a = '0;
			press_cal_b = '0;
			press_cal_c = '0;
			fine_temp   = '0;
			mismatches  = 0;
		endfunction

		function void write_register(logic [1:0] idx, logic [47:0] value);
			case (idx)
				ptc_pkg::CFG_TEMP:    temp_cal    = value;
				ptc_pkg::CFG_PRESS_A: press_cal_a = value;
				ptc_pkg::CFG_PRESS_B: press_cal_b = value;
				ptc_pkg::CFG_PRESS_C: press_cal_c = value;
				default: ;
			endcase
		endfunction

		// Coefficient in slot 0, 1 or 2 of a packed word, widened to 64 bits.
		function logic [63:0] coef(logic [47:0] word, int slot, bit is_signed);
			logic [15:0] raw;
			raw = word[16*slot +: 16];
			return is_signed ? {{48{raw[15]}}, raw} : {48'd0, raw};
		endfunction

		function logic [63:0] asr(logic [63:0] x, int unsigned n);
			logic signed [63:0] s;
			s = x;
			return s >>> n;
		endfunction

		// Signed division truncating towards zero, done on magnitudes so that
		// the most negative value over minus one wraps onto itself.
		function logic [63:0] div_trunc(logic [63:0] num, logic [63:0] den);
			logic [63:0] mag_n;
			logic [63:0] mag_d;
			logic [63:0] q;
			mag_n = num[63] ? 64'd0 - num : num;
			mag_d = den[63] ? 64'd0 - den : den;
			q = mag_n / mag_d;
			return (num[63] ^ den[63]) ? 64'd0 - q : q;
		endfunction

		function reading_t compensate(logic req, logic [19:0] raw);
			logic [63:0] adc, t1, t2, t3, d1, d2, v1, v2, tf, fs, scaled;
			logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
			logic [63:0] a, b, p, ps;
			reading_t r;
			r = '0;
			r.kind = req;
			adc = {44'd0, raw};
			fs = {{32{fine_temp[31]}}, fine_temp};
			if (!req) begin
				t1 = coef(temp_cal, 0, 1'b0);
				t2 = coef(temp_cal, 1, 1'b1);
				t3 = coef(temp_cal, 2, 1'b1);
				d1 = (adc >> 3) - (t1 << 1);
				v1 = asr(d1 * t2, 11);
				d2 = (adc >> 4) - t1;
				v2 = asr(asr(d2 * d2, 12) * t3, 14);
				tf = v1 + v2;
				fine_temp = tf[31:0];
				fs = {{32{fine_temp[31]}}, fine_temp};
				scaled = asr(fs * 64'd5 + 64'd128, 8);
				r.temp = scaled[31:0];
			end else begin
				p1 = coef(press_cal_a, 0, 1'b0);
				p2 = coef(press_cal_a, 1, 1'b1);
				p3 = coef(press_cal_a, 2, 1'b1);
				p4 = coef(press_cal_b, 0, 1'b1);
				p5 = coef(press_cal_b, 1, 1'b1);
				p6 = coef(press_cal_b, 2, 1'b1);
				p7 = coef(press_cal_c, 0, 1'b1);
				p8 = coef(press_cal_c, 1, 1'b1);
				p9 = coef(press_cal_c, 2, 1'b1);
				a = fs - 64'd128000;
				b = a * a * p6;
				b = b + ((a * p5) << 17);
				b = b + (p4 << 35);
				a = asr(a * a * p3, 8) + ((a * p2) << 12);
				a = asr(((64'd1 << 47) + a) * p1, 33);
				if (a == 64'd0) begin
					r.fault = 1'b1;
				end else begin
					p = 64'd1048576 - adc;
					p = div_trunc(((p << 31) - b) * 64'd3125, a);
					ps = asr(p, 13);
					a = asr(p9 * ps * ps, 25);
					b = asr(p8 * p, 19);
					p = asr(p + a + b, 8) + (p7 << 4);
					r.press = p[31:0];
				end
			end
			return r;
		endfunction

		function void note_sample(logic req, logic [19:0] raw);
			readings_due.push_back(compensate(req, raw));
		endfunction

		function void compare_field(string what, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
				mismatches++;
			end
		endfunction

		function void check_reading(logic k, logic [31:0] t, logic [31:0] p, logic f);
			reading_t want;
			if (readings_due.size() == 0) begin
				$display("%0t: result with nothing outstanding, expected none, actual kind %0d",
					$time, k);
				mismatches++;
				return;
			end
			want = readings_due.pop_front();
			compare_field("kind", {31'd0, want.kind}, {31'd0, k});
			compare_field("temp_centi", want.temp, t);
			compare_field("pressure_q24_8", want.press, p);
			compare_field("div_fault", {31'd0, want.fault}, {31'd0, f});
		endfunction

		function int pending();
			return readings_due.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               req_type;
	logic [19:0]        raw_sample;
	logic               out_valid;
	logic               out_stall;
	logic               kind;
	logic signed [31:0] temp_centi;
	logic [31:0]        pressure_q24_8;
	logic               div_fault;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [47:0]        cfg_data;

	reading_tracker sb;
	bit             calm;
	int unsigned    cycle_count;

	pressure_temperature_compensation dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.raw_sample     (raw_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.temp_centi     (temp_centi),
		.pressure_q24_8 (pressure_q24_8),
		.div_fault      (div_fault),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: if the run has not ended by the cycle limit, something hung.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side back-pressure. Each step makes exactly one assignment to
	// out_stall: at random a stall burst, then a free stretch that is now and
	// then long, so that stalls land at varied points of a transaction.
	initial begin
		out_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_stall <= 1'b0;
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(60, 200)) @(posedge clk);
			else
				repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// Result monitor. Values are read in the active region of the edge, so
	// they are the ones the block presented as the edge arrived.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_reading(kind, temp_centi, pressure_q24_8, div_fault);
	end

	function automatic logic [47:0] pack3(logic [15:0] lo, logic [15:0] mid, logic [15:0] hi);
		return {hi, mid, lo};
	endfunction

	function automatic logic [15:0] jitter(logic [15:0] v, int unsigned span);
		return v + 16'($urandom_range(0, 2 * span)) - 16'(span);
	endfunction

	function automatic logic [47:0] any_word();
		return 48'({$urandom, $urandom});
	endfunction

	// Raw readings are mostly near a sensible operating point, with a share
	// of full-range values and the two end points of the converter.
	function automatic logic [19:0] pick_raw(logic is_press);
		int unsigned sel;
		int unsigned centre;
		sel = $urandom_range(0, 19);
		centre = is_press ? RAW_PRESS_CENTRE : RAW_TEMP_CENTRE;
		if (sel < 5)
			return 20'($urandom);
		else if (sel == 5)
			return 20'd0;
		else if (sel == 6)
			return RAW_MAX;
		else
			return 20'(centre + $urandom_range(0, 32768) - 16384);
	endfunction

	// Offers one input transaction and returns at the edge that accepted it.
	// It is called at a rising edge, either the one that accepted the previous
	// transaction or one where in_valid is already low, so in_valid gets at
	// most one assignment per step and stays high across back-to-back items.
	task automatic send(logic r, logic [19:0] s);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid   <= 1'b0;
			req_type   <= 1'($urandom);
			raw_sample <= 20'($urandom);
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= r;
		raw_sample <= s;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_sample(r, s);
	endtask

	// Holds the sender off until every outstanding reading has come back.
	// Every transaction gives a result, so the block is idle once this ends.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [47:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_register(idx, value);
	endtask

	// Loads a complete calibration set while the block is idle.
	task automatic load_calib(logic [47:0] t, logic [47:0] a, logic [47:0] b,
		logic [47:0] c);
		drain();
		write_reg(ptc_pkg::CFG_TEMP, t);
		write_reg(ptc_pkg::CFG_PRESS_A, a);
		write_reg(ptc_pkg::CFG_PRESS_B, b);
		write_reg(ptc_pkg::CFG_PRESS_C, c);
		cfg_valid <= 1'b0;
	endtask

	// Datasheet example calibration, with optional random spread per field.
	task automatic load_typical(int unsigned span);
		load_calib(
			pack3(jitter(16'd27504, span), jitter(16'd26435, span),
				jitter(16'(-1000), span)),
			pack3(jitter(16'd36477, span), jitter(16'(-10685), span),
				jitter(16'd3024, span)),
			pack3(jitter(16'd2855, span), jitter(16'd140, span), jitter(16'(-7), span)),
			pack3(jitter(16'd15500, span), jitter(16'(-14600), span),
				jitter(16'd6000, span)));
	endtask

	// Random traffic. Most of it is the normal usage pattern, a temperature
	// reading followed by a few pressure readings that depend on it; the rest
	// is loose transactions of either kind. Half way through, the sender
	// waits for all outstanding readings before going on.
	task automatic random_items(int count);
		int sent;
		int burst;
		bit held;
		sent = 0;
		held = 0;
		while (sent < count) begin
			if (!held && sent >= count / 2) begin
				drain();
				held = 1;
			end
			if ($urandom_range(0, 9) < 7) begin
				send(1'b0, pick_raw(1'b0));
				sent++;
				burst = $urandom_range(1, 3);
				for (int i = 0; i < burst; i++) begin
					send(1'b1, pick_raw(1'b1));
					sent++;
				end
			end else begin
				send(1'($urandom), 20'($urandom));
				sent++;
			end
		end
	endtask

	// Directed opening: pressure before any temperature, the zero divisor
	// both from reset and with an otherwise sensible set, the converter end
	// points and the coefficient extremes.
	task automatic directed();
		// From reset every coefficient is zero, so the divisor is zero and the
		// fine temperature starts at zero.
		send(1'b1, 20'(RAW_PRESS_CENTRE));
		send(1'b0, 20'(RAW_TEMP_CENTRE));
		send(1'b1, RAW_MAX);

		load_typical(0);
		send(1'b1, 20'(RAW_PRESS_CENTRE));
		send(1'b0, 20'd0);
		send(1'b0, RAW_MAX);
		send(1'b0, 20'(RAW_TEMP_CENTRE));
		send(1'b1, 20'd0);
		send(1'b1, RAW_MAX);
		send(1'b1, 20'(RAW_PRESS_CENTRE));

		// A zero P1 forces the divisor to zero whatever else is loaded.
		load_calib(pack3(16'd27504, 16'd26435, 16'(-1000)),
			pack3(16'd0, 16'(-10685), 16'd3024),
			pack3(16'd2855, 16'd140, 16'(-7)),
			pack3(16'd15500, 16'(-14600), 16'd6000));
		send(1'b0, 20'(RAW_TEMP_CENTRE));
		send(1'b1, 20'(RAW_PRESS_CENTRE));

		load_calib({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
		send(1'b0, 20'd0);
		send(1'b1, RAW_MAX);
		send(1'b0, RAW_MAX);
		send(1'b1, 20'd0);

		load_calib(pack3(16'hFFFF, 16'h7FFF, 16'h7FFF), pack3(16'hFFFF, 16'h7FFF, 16'h7FFF),
			{3{16'h7FFF}}, {3{16'h7FFF}});
		send(1'b0, RAW_MAX);
		send(1'b1, 20'd0);
		send(1'b0, 20'd0);
		send(1'b1, RAW_MAX);

		load_calib(pack3(16'h0000, 16'h8000, 16'h8000), pack3(16'h0001, 16'h8000, 16'h8000),
			{3{16'h8000}}, {3{16'h8000}});
		send(1'b0, RAW_MAX);
		send(1'b1, 20'd0);
		send(1'b0, 20'd0);
		send(1'b1, RAW_MAX);
	endtask

	initial begin
		sb         = new();
		calm       = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		req_type   = 1'b0;
		raw_sample = '0;
		cfg_valid  = 1'b0;
		cfg_index  = ptc_pkg::CFG_TEMP;
		cfg_data   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();

		load_typical(0);
		random_items(250);
		load_typical(512);
		random_items(250);
		load_calib(any_word(), any_word(), any_word(), any_word());
		random_items(250);
		load_calib({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
		random_items(150);
		load_calib(pack3(16'hFFFF, 16'h7FFF, 16'h7FFF), pack3(16'hFFFF, 16'h7FFF, 16'h7FFF),
			{3{16'h7FFF}}, {3{16'h7FFF}});
		random_items(150);
		load_calib(pack3(16'h0000, 16'h8000, 16'h8000), pack3(16'h0001, 16'h8000, 16'h8000),
			{3{16'h8000}}, {3{16'h8000}});
		random_items(150);

		// Final stretch runs flat out on both sides.
		calm = 1'b1;
		load_typical(512);
		random_items(230);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/ptc_pkg.sv
rtl/ptc_mul.sv
rtl/ptc_div.sv
rtl/pressure_temperature_compensation.sv
dv/tb_pressure_temperature_compensation.sv
